[sv/gbsrp_pkg.sv]
package gbsrp_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [1:0] kind_t;

    localparam kind_t KIND_PUSH   = 2'd0;
    localparam kind_t KIND_SELECT = 2'd1;
    localparam kind_t KIND_READ   = 2'd2;

    localparam byte_t REG_COUNT_HIGH = 8'hFD;
    localparam byte_t REG_COUNT_LOW  = 8'hFE;
    localparam byte_t REG_STREAM     = 8'hFF;
    localparam byte_t EMPTY_READ     = 8'hFF;
    localparam byte_t IDLE_READ      = 8'h00;

    localparam int COUNT_VIEW_W = 16;

endpackage

[sv/gbsrp_byte_ram.sv]
module gbsrp_byte_ram #(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  gbsrp_pkg::byte_t    wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output gbsrp_pkg::byte_t    rd_data
);
    import gbsrp_pkg::*;

    byte_t mem [DEPTH];
    byte_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/gnss_byte_stream_register_port.sv]
// Byte-stream register port. Pushes, register selects and reads of the count
// registers (0xFD high byte, 0xFE low byte) do not raise busy, and a new
// transaction may be started on every cycle that busy is low. A read of the
// stream register (0xFF) that finds data raises busy: busy is high for
// one cycle while the byte store, a registered single-port-read memory,
// returns the oldest byte. Every read transaction gives exactly one
// result: done is high for one cycle with read_data, in the cycle after
// the store access completes, and the receiver cannot stall it. A push into a
// full store drops the oldest byte. No clearing pass follows reset.
module gnss_byte_stream_register_port #(
    parameter int BUFFER_DEPTH = 512
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  gbsrp_pkg::kind_t   kind,
    input  gbsrp_pkg::byte_t   data_byte,
    output logic               done,
    output gbsrp_pkg::byte_t   read_data
);
    import gbsrp_pkg::*;

    localparam int PTR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    byte_t              sel_reg, sel_next;
    byte_t              read_data_reg, read_data_next;
    logic               done_reg, done_next;

    logic               accept;
    logic               full;
    logic               empty;
    logic [COUNT_VIEW_W-1:0] count_view;
    logic               mem_wr_en;
    logic               mem_rd_en;
    byte_t              mem_q;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        advance = (p == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign busy       = (state_reg == ST_READ);
    assign accept     = start && !busy;
    assign full       = (count_reg == CNT_W'(BUFFER_DEPTH));
    assign empty      = (count_reg == '0);
    assign count_view = COUNT_VIEW_W'(count_reg);

    always_comb
    begin
        state_next     = state_reg;
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        count_next     = count_reg;
        sel_next       = sel_reg;
        read_data_next = read_data_reg;
        done_next      = 1'b0;
        mem_wr_en      = 1'b0;
        mem_rd_en      = 1'b0;

        if (state_reg == ST_READ)
        begin
            read_data_next = mem_q;
            done_next      = 1'b1;
            state_next     = ST_IDLE;
        end
        else if (accept)
        begin
            case (kind)
                KIND_PUSH:
                begin
                    mem_wr_en   = 1'b1;
                    wr_ptr_next = advance(wr_ptr_reg);
                    if (full)
                    begin
                        rd_ptr_next = advance(rd_ptr_reg);
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                KIND_SELECT:
                begin
                    sel_next = data_byte;
                end
                KIND_READ:
                begin
                    case (sel_reg)
                        REG_COUNT_HIGH:
                        begin
                            read_data_next = count_view[15:8];
                            done_next      = 1'b1;
                        end
                        REG_COUNT_LOW:
                        begin
                            read_data_next = count_view[7:0];
                            done_next      = 1'b1;
                        end
                        REG_STREAM:
                        begin
                            if (empty)
                            begin
                                read_data_next = EMPTY_READ;
                                done_next      = 1'b1;
                            end
                            else
                            begin
                                mem_rd_en   = 1'b1;
                                rd_ptr_next = advance(rd_ptr_reg);
                                count_next  = count_reg - 1'b1;
                                state_next  = ST_READ;
                            end
                        end
                        default:
                        begin
                            read_data_next = IDLE_READ;
                            done_next      = 1'b1;
                        end
                    endcase
                end
                default:
                begin
                    // drop the unused kind
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            sel_reg       <= REG_STREAM;
            read_data_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            count_reg     <= count_next;
            sel_reg       <= sel_next;
            read_data_reg <= read_data_next;
            done_reg      <= done_next;
        end
    end

    gbsrp_byte_ram #(
        .DEPTH  (BUFFER_DEPTH),
        .ADDR_W (PTR_W)
    ) u_byte_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (wr_ptr_reg),
        .wr_data (data_byte),
        .rd_en   (mem_rd_en),
        .rd_addr (rd_ptr_reg),
        .rd_data (mem_q)
    );

    assign done      = done_reg;
    assign read_data = read_data_reg;

endmodule
